>>> sv/lcdseq_pkg.sv
package lcdseq_pkg;

   localparam int TICK_WIDTH = 24;
   localparam int INIT_COUNT = 7;
   localparam int INIT_INDEX_WIDTH = 3;

   // register indexes on the csr port
   localparam logic CSR_ENABLE_PULSE = 1'b0;
   localparam logic CSR_SETTLE       = 1'b1;

   // operation codes of a request word
   typedef enum logic [1:0] {
      OP_COMMAND = 2'd0,
      OP_DATA    = 2'd1,
      OP_GOTO    = 2'd2,
      OP_INIT    = 2'd3
   } operation_type;

   // one classified request, as it waits in the queue
   typedef struct packed {
      logic       is_init;
      logic       reg_select;
      logic [7:0] byte_value;
   } entry_type;

   // phase hold times from the csr registers
   typedef struct packed {
      logic [TICK_WIDTH-1:0] enable_pulse_ticks;
      logic [TICK_WIDTH-1:0] settle_ticks;
   } timing_type;

   // power-up command sequence
   function automatic logic [7:0] init_command(input logic [INIT_INDEX_WIDTH-1:0] index);
      logic [7:0] value;
      unique case (index)
         3'd0:    value = 8'h33;
         3'd1:    value = 8'h32;
         3'd2:    value = 8'h28;
         3'd3:    value = 8'h0C;
         3'd4:    value = 8'h01;
         3'd5:    value = 8'h06;
         3'd6:    value = 8'h02;
         default: value = 8'h02;
      endcase
      return value;
   endfunction

endpackage

>>> sv/lcdseq_if.sv
// request channel
interface lcdseq_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] byte_value;
   logic       row;
   logic [5:0] column;

   modport source (output valid, output operation, output byte_value, output row,
                   output column, input ready);
   modport sink (input valid, input operation, input byte_value, input row,
                 input column, output ready);
endinterface

// response channel, one word per pin phase
interface lcdseq_rsp_if;
   logic        valid;
   logic        ready;
   logic        reg_select;
   logic        enable_level;
   logic [3:0]  data_nibble;
   logic [23:0] hold_ticks;
   logic        last;

   modport source (output valid, output reg_select, output enable_level,
                   output data_nibble, output hold_ticks, output last, input ready);
   modport sink (input valid, input reg_select, input enable_level,
                 input data_nibble, input hold_ticks, input last, output ready);
endinterface

>>> sv/lcdseq_front.sv
module lcdseq_front (
   input  logic                  clock,
   input  logic                  reset,
   lcdseq_req_if.sink            req,
   output logic                  push_valid,
   input  logic                  push_ready,
   output lcdseq_pkg::entry_type push_entry
);
   import lcdseq_pkg::*;

   logic      valid_ff;
   entry_type entry_ff;
   entry_type entry_in;

   // classify the request word
   always_comb begin
      entry_in = '0;
      unique case (operation_type'(req.operation))
         OP_COMMAND: begin
            entry_in.reg_select = 1'b0;
            entry_in.byte_value = req.byte_value;
         end
         OP_DATA: begin
            entry_in.reg_select = 1'b1;
            entry_in.byte_value = req.byte_value;
         end
         OP_GOTO: begin
            // row base 0x80 or 0xc0, column fits below bit 6
            entry_in.reg_select = 1'b0;
            entry_in.byte_value = {1'b1, req.row, req.column};
         end
         OP_INIT: begin
            entry_in.is_init = 1'b1;
         end
         default: entry_in = '0;
      endcase
   end

   assign req.ready  = !valid_ff || push_ready;
   assign push_valid = valid_ff;
   assign push_entry = entry_ff;

   // one-entry holding register in front of the queue
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req.valid && req.ready) begin
         valid_ff <= 1'b1;
         entry_ff <= entry_in;
      end else if (push_ready) begin
         valid_ff <= 1'b0;
      end
   end

endmodule

>>> sv/lcdseq_queue.sv
module lcdseq_queue #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  lcdseq_pkg::entry_type push_entry,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output lcdseq_pkg::entry_type pop_entry
);
   import lcdseq_pkg::*;

   localparam int PTR_WIDTH   = $clog2(DEPTH);
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0]   LAST_PTR   = PTR_WIDTH'(DEPTH - 1);
   localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(DEPTH);

   entry_type                storage_ff [DEPTH];
   logic [PTR_WIDTH-1:0]     wr_ptr_ff;
   logic [PTR_WIDTH-1:0]     rd_ptr_ff;
   logic [COUNT_WIDTH-1:0]   count_ff;
   logic                     do_push;
   logic                     do_pop;

   assign push_ready = count_ff != FULL_COUNT;
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = storage_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         storage_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

>>> sv/lcdseq_back.sv
module lcdseq_back (
   input  logic                   clock,
   input  logic                   reset,
   input  lcdseq_pkg::timing_type timing,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  lcdseq_pkg::entry_type  pop_entry,
   lcdseq_rsp_if.source           rsp
);
   import lcdseq_pkg::*;

   typedef enum logic [2:0] {
      PH_HI_SETUP,
      PH_HI_PULSE,
      PH_LO_SETUP,
      PH_LO_PULSE,
      PH_SETTLE
   } phase_type;

   phase_type                   phase_ff;
   logic                        busy_ff;
   entry_type                   entry_ff;
   logic [INIT_INDEX_WIDTH-1:0] index_ff;
   logic                        out_valid_ff;
   logic                        out_rs_ff;
   logic                        out_e_ff;
   logic [3:0]                  out_nibble_ff;
   logic [TICK_WIDTH-1:0]       out_hold_ff;
   logic                        out_last_ff;

   logic [7:0]                  cur_byte;
   logic                        final_byte;
   logic                        advance;
   logic                        last_step;
   logic                        out_e_in;
   logic [3:0]                  out_nibble_in;
   logic [TICK_WIDTH-1:0]       out_hold_in;

   // byte under way and whether it closes the request
   assign cur_byte   = entry_ff.is_init ? init_command(index_ff) : entry_ff.byte_value;
   assign final_byte = !entry_ff.is_init ||
                       (index_ff == INIT_INDEX_WIDTH'(INIT_COUNT - 1));
   assign advance    = busy_ff && (!out_valid_ff || rsp.ready);
   assign last_step  = (phase_ff == PH_SETTLE) && final_byte;
   assign pop_ready  = !busy_ff || (advance && last_step);

   // pin levels of the current phase
   always_comb begin
      unique case (phase_ff)
         PH_HI_SETUP: begin
            out_e_in = 1'b0; out_nibble_in = cur_byte[7:4]; out_hold_in = '0;
         end
         PH_HI_PULSE: begin
            out_e_in = 1'b1; out_nibble_in = cur_byte[7:4];
            out_hold_in = timing.enable_pulse_ticks;
         end
         PH_LO_SETUP: begin
            out_e_in = 1'b0; out_nibble_in = cur_byte[3:0]; out_hold_in = '0;
         end
         PH_LO_PULSE: begin
            out_e_in = 1'b1; out_nibble_in = cur_byte[3:0];
            out_hold_in = timing.enable_pulse_ticks;
         end
         PH_SETTLE: begin
            out_e_in = 1'b0; out_nibble_in = cur_byte[3:0];
            out_hold_in = timing.settle_ticks;
         end
         default: begin
            out_e_in = 1'b0; out_nibble_in = '0; out_hold_in = '0;
         end
      endcase
   end

   // phase sequencer with registered response word
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_HI_SETUP;
         index_ff     <= '0;
      end else begin
         // response word register
         if (advance) begin
            out_valid_ff  <= 1'b1;
            out_rs_ff     <= entry_ff.reg_select;
            out_e_ff      <= out_e_in;
            out_nibble_ff <= out_nibble_in;
            out_hold_ff   <= out_hold_in;
            out_last_ff   <= last_step;
         end else if (out_valid_ff && rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
         // take the next queued request, else step through the phases
         if (pop_valid && pop_ready) begin
            entry_ff <= pop_entry;
            busy_ff  <= 1'b1;
            index_ff <= '0;
            phase_ff <= PH_HI_SETUP;
         end else if (advance) begin
            unique case (phase_ff)
               PH_HI_SETUP: phase_ff <= PH_HI_PULSE;
               PH_HI_PULSE: phase_ff <= PH_LO_SETUP;
               PH_LO_SETUP: phase_ff <= PH_LO_PULSE;
               PH_LO_PULSE: phase_ff <= PH_SETTLE;
               PH_SETTLE: begin
                  phase_ff <= PH_HI_SETUP;
                  if (final_byte) begin
                     busy_ff <= 1'b0;
                  end else begin
                     index_ff <= index_ff + 1'b1;
                  end
               end
               default: phase_ff <= PH_HI_SETUP;
            endcase
         end
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.reg_select   = out_rs_ff;
   assign rsp.enable_level = out_e_ff;
   assign rsp.data_nibble  = out_nibble_ff;
   assign rsp.hold_ticks   = out_hold_ff;
   assign rsp.last         = out_last_ff;

endmodule

>>> sv/char_lcd_nibble_write_sequencer_unit.sv
// a taken request word passes the front holding register, the queue and the
// sequencer's entry register before its first phase word is registered; phase words
// follow one per cycle unless rsp.ready stalls, 5 per command, data or go-to request
// and 35 per init request; a small queue between classifier and sequencer lets the
// request side run ahead; reset (synchronous, active high) empties the queue and the
// sequencer and restores enable_pulse_ticks to 50000 and settle_ticks to 250000
module char_lcd_nibble_write_sequencer_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   lcdseq_req_if.sink  req,
   lcdseq_rsp_if.source rsp,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [23:0] csr_write_data
);
   import lcdseq_pkg::*;

   logic [TICK_WIDTH-1:0] enable_pulse_ticks_ff;
   logic [TICK_WIDTH-1:0] settle_ticks_ff;
   timing_type            timing;
   logic                  push_valid;
   logic                  push_ready;
   entry_type             push_entry;
   logic                  pop_valid;
   logic                  pop_ready;
   entry_type             pop_entry;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_pulse_ticks_ff <= TICK_WIDTH'(50000);
         settle_ticks_ff       <= TICK_WIDTH'(250000);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ENABLE_PULSE: enable_pulse_ticks_ff <= csr_write_data;
            CSR_SETTLE:       settle_ticks_ff       <= csr_write_data;
            default:          enable_pulse_ticks_ff <= enable_pulse_ticks_ff;
         endcase
      end
   end

   assign timing.enable_pulse_ticks = enable_pulse_ticks_ff;
   assign timing.settle_ticks       = settle_ticks_ff;

   lcdseq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   lcdseq_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   lcdseq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .timing    (timing),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp       (rsp)
   );

endmodule
